### design/gb5_pkg.sv
// ----------------------------------------------------------------------------
// gb5_pkg: shared types and constants for the 5x5 RGBA blur
// Kernel weights in unsigned Q0.16, accumulator sizing and the control
// bundle that drives the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package gb5_pkg;

   localparam int CHANNELS  = 4;
   localparam int CHAN_W    = 8;
   localparam int PIXEL_W   = CHANNELS * CHAN_W;
   localparam int WEIGHT_W  = 14;
   // 255 * 65323 stays below 2**24.
   localparam int ACC_W     = 24;
   localparam int ROUND_SH  = 16;
   localparam int KSIZE     = 5;
   localparam int TAP_W     = 3;

   localparam logic [TAP_W-1:0] TAP_LAST = 3'd4;
   localparam logic [TAP_W-1:0] TAP_MID  = 3'd2;

   localparam logic [WEIGHT_W-1:0] BLUR_WEIGHT [KSIZE][KSIZE] = '{
      '{14'd52,  14'd430,  14'd872,   14'd430,  14'd52 },
      '{14'd430, 14'd3586, 14'd7273,  14'd3586, 14'd430},
      '{14'd872, 14'd7273, 14'd14751, 14'd7273, 14'd872},
      '{14'd430, 14'd3586, 14'd7273,  14'd3586, 14'd430},
      '{14'd52,  14'd430,  14'd872,   14'd430,  14'd52 }
   };

   typedef struct packed {
      logic valid;
      logic first;
   } mac_ctl_type;

endpackage

### design/gaussian_blur_5x5_rgba.sv
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_rgba: 5x5 Gaussian blur of a small RGBA frame
// Loads a frame in raster order, then streams the blurred frame out.
// ----------------------------------------------------------------------------
// Usage:
// A pixel transaction is taken on a clock edge where start is high and busy
// is low. Pixels arrive in raster order, one per cycle at most, while busy
// stays low. The edge that takes the last pixel of the frame raises busy.
// The frame is then filtered with clamped borders: one multiplier per
// channel walks the 25 kernel taps for each output pixel, and the results
// leave in raster order. Each result sits on rsp_pixel_out for one cycle
// with rsp_strobe high; rsp_last_pixel marks the final one. The receiver
// cannot stall. busy falls in the cycle of the final result, and the next
// frame may start there.
// Synchronous reset returns the block to loading at pixel zero; the frame
// store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_rgba
   import gb5_pkg::*;
#(
   parameter int IMG_WIDTH  = 4,
   parameter int IMG_HEIGHT = 4
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [PIXEL_W-1:0] req_pixel_in,
   output logic               rsp_strobe,
   output logic [PIXEL_W-1:0] rsp_pixel_out,
   output logic               rsp_last_pixel
);

   localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (IMG_WIDTH > 1) ? $clog2(IMG_WIDTH) : 1;
   localparam int RW    = (IMG_HEIGHT > 1) ? $clog2(IMG_HEIGHT) : 1;

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [PIXEL_W-1:0] frame_mem [DEPTH];

   logic [1:0]       state_ff, state_in;
   logic [AW-1:0]    load_count_ff, load_count_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [TAP_W-1:0] dy_ff, dy_in;
   logic [TAP_W-1:0] dx_ff, dx_in;

   logic               take;
   logic               issue;
   logic               tap_first, tap_last, tap_final;
   logic [AW-1:0]      rd_addr;
   logic [PIXEL_W-1:0] rd_data_ff;
   logic [WEIGHT_W-1:0] s1_weight_ff;
   mac_ctl_type        s1_ctl_ff;
   logic               s1_last_ff, s1_final_ff;
   logic               done_ff, done_final_ff;
   logic [PIXEL_W-1:0] blur_pixel;
   logic               rsp_strobe_ff;
   logic [PIXEL_W-1:0] rsp_pixel_out_ff;
   logic               rsp_last_pixel_ff;

   assign take  = start && !busy;
   assign issue = (state_ff == ST_ISSUE);
   assign busy  = (state_ff != ST_LOAD);

   assign tap_first = (dy_ff == '0) && (dx_ff == '0);
   assign tap_last  = (dy_ff == TAP_LAST) && (dx_ff == TAP_LAST);
   assign tap_final = tap_last && (row_ff == RW'(IMG_HEIGHT - 1)) &&
                      (col_ff == CW'(IMG_WIDTH - 1));

   // Neighbor address with coordinates clamped to the frame.
   always_comb begin
      logic signed [4:0] ys, xs;
      logic [RW-1:0]     yc;
      logic [CW-1:0]     xc;
      ys = signed'(5'({1'b0, row_ff})) + signed'(5'(dy_ff)) - signed'(5'(TAP_MID));
      xs = signed'(5'({1'b0, col_ff})) + signed'(5'(dx_ff)) - signed'(5'(TAP_MID));
      priority if (ys < 0) begin
         yc = '0;
      end else if (ys > 5'(IMG_HEIGHT - 1)) begin
         yc = RW'(IMG_HEIGHT - 1);
      end else begin
         yc = ys[RW-1:0];
      end
      priority if (xs < 0) begin
         xc = '0;
      end else if (xs > 5'(IMG_WIDTH - 1)) begin
         xc = CW'(IMG_WIDTH - 1);
      end else begin
         xc = xs[CW-1:0];
      end
      rd_addr = AW'(AW'(yc) * AW'(IMG_WIDTH)) + AW'(xc);
   end

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      dy_in         = dy_ff;
      dx_in         = dx_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (take) begin
               if (load_count_ff == AW'(DEPTH - 1)) begin
                  load_count_in = '0;
                  row_in        = '0;
                  col_in        = '0;
                  dy_in         = '0;
                  dx_in         = '0;
                  state_in      = ST_ISSUE;
               end else begin
                  load_count_in = load_count_ff + 1'b1;
               end
            end
         end
         ST_ISSUE: begin
            if (dx_ff != TAP_LAST) begin
               dx_in = dx_ff + 1'b1;
            end else begin
               dx_in = '0;
               if (dy_ff != TAP_LAST) begin
                  dy_in = dy_ff + 1'b1;
               end else begin
                  dy_in = '0;
                  if (col_ff != CW'(IMG_WIDTH - 1)) begin
                     col_in = col_ff + 1'b1;
                  end else begin
                     col_in = '0;
                     if (row_ff != RW'(IMG_HEIGHT - 1)) begin
                        row_in = row_ff + 1'b1;
                     end else begin
                        state_in = ST_DRAIN;
                     end
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (done_ff && done_final_ff) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_count_ff <= '0;
         s1_ctl_ff     <= '0;
         done_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         load_count_ff   <= load_count_in;
         s1_ctl_ff.valid <= issue;
         s1_ctl_ff.first <= issue && tap_first;
         done_ff         <= s1_ctl_ff.valid && s1_last_ff;
         rsp_strobe_ff   <= done_ff;
      end
   end

   always_ff @(posedge clock) begin
      row_ff            <= row_in;
      col_ff            <= col_in;
      dy_ff             <= dy_in;
      dx_ff             <= dx_in;
      s1_weight_ff      <= BLUR_WEIGHT[dy_ff][dx_ff];
      s1_last_ff        <= tap_last;
      s1_final_ff       <= tap_final;
      done_final_ff     <= s1_final_ff;
      rsp_pixel_out_ff  <= blur_pixel;
      rsp_last_pixel_ff <= done_final_ff;
   end

   // Frame store: written while loading, read one tap per cycle.
   always_ff @(posedge clock) begin
      if (take) begin
         frame_mem[load_count_ff] <= req_pixel_in;
      end
      rd_data_ff <= frame_mem[rd_addr];
   end

   gb5_mac u_mac (
      .clock      (clock),
      .mac_ctl    (s1_ctl_ff),
      .tap_pixel  (rd_data_ff),
      .tap_weight (s1_weight_ff),
      .blur_pixel (blur_pixel)
   );

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_pixel_out  = rsp_pixel_out_ff;
   assign rsp_last_pixel = rsp_last_pixel_ff;

`ifndef NO_ASSERTIONS
   // The multiply-accumulate unit only works while a frame is filtered.
   a_mac_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      s1_ctl_ff.valid |-> (state_ff != ST_LOAD))
      else $error("MAC active while loading");

   // Completing a frame starts the filter pass.
   a_frame_starts_pass: assert property (@(posedge clock) disable iff (reset)
      (take && (load_count_ff == AW'(DEPTH - 1))) |=> (state_ff == ST_ISSUE))
      else $error("filter pass did not start after the last pixel");

   // Nothing follows the final result of a frame in the next cycle.
   a_no_result_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_pixel) |=> !rsp_strobe)
      else $error("result emitted right after the final pixel");

   // A finished pixel only appears while the block is busy.
   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> busy)
      else $error("pixel finished while idle");
`endif

endmodule

### design/gb5_mac.sv
// ----------------------------------------------------------------------------
// gb5_mac: four-channel multiply-accumulate unit with round and saturate
// One 8x14 product per channel is added each cycle that mac_ctl.valid is
// high; the rounded, clamped channel sums are presented as a packed RGBA word.
// ----------------------------------------------------------------------------
module gb5_mac
   import gb5_pkg::*;
(
   input  logic                clock,
   input  mac_ctl_type         mac_ctl,
   input  logic [PIXEL_W-1:0]  tap_pixel,
   input  logic [WEIGHT_W-1:0] tap_weight,
   output logic [PIXEL_W-1:0]  blur_pixel
);

   logic [ACC_W-1:0] acc_ff [CHANNELS];
   logic [ACC_W-1:0] acc_in [CHANNELS];

   always_comb begin
      logic [ACC_W-1:0] prod;
      for (int c = 0; c < CHANNELS; c++) begin
         prod = ACC_W'(tap_pixel[c*CHAN_W +: CHAN_W]) * ACC_W'(tap_weight);
         if (mac_ctl.first) begin
            acc_in[c] = prod;
         end else begin
            acc_in[c] = acc_ff[c] + prod;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (mac_ctl.valid) begin
            acc_ff[c] <= acc_in[c];
         end
      end
   end

   // Round half up, then clamp to the channel range.
   always_comb begin
      logic [ACC_W:0]              rounded;
      logic [ACC_W-ROUND_SH:0]     whole;
      for (int c = 0; c < CHANNELS; c++) begin
         rounded = {1'b0, acc_ff[c]} + (ACC_W+1)'(1 << (ROUND_SH - 1));
         whole   = rounded[ACC_W:ROUND_SH];
         if (whole > (ACC_W-ROUND_SH+1)'(255)) begin
            blur_pixel[c*CHAN_W +: CHAN_W] = 8'hFF;
         end else begin
            blur_pixel[c*CHAN_W +: CHAN_W] = whole[CHAN_W-1:0];
         end
      end
   end

endmodule
